// ===== rtl/ssdl_pkg.sv =====
// ----------------------------------------------------------------------------
// Sparse symmetric distance lookup: shared package
// Sizes, command and status codes, sequencer states and the structs that
// travel between the search sequencer, the tables and the top level.
// ----------------------------------------------------------------------------
package ssdl_pkg;

   // Table sizes.
   localparam int MAX_ITEMS    = 4096;
   localparam int MAX_ENTRIES  = 65536;

   // Field widths of the word formats.
   localparam int CMD_W        = 2;
   localparam int FIRST_W      = 13;
   localparam int SECOND_W     = 12;
   localparam int POS_W        = 17;
   localparam int DIST_W       = 8;
   localparam int STATUS_W     = 2;

   // Derived memory address widths.
   localparam int ROW_ADDR_W   = $clog2(MAX_ITEMS + 1);
   localparam int ENTRY_ADDR_W = $clog2(MAX_ENTRIES);

   // Request payload layout in req_tdata.
   localparam int REQ_DATA_W   = ((FIRST_W + SECOND_W + POS_W + DIST_W + 7) / 8) * 8;
   localparam int FIRST_LSB    = 0;
   localparam int SECOND_LSB   = FIRST_LSB + FIRST_W;
   localparam int POS_LSB      = SECOND_LSB + SECOND_W;
   localparam int DIST_LSB     = POS_LSB + POS_W;

   // Configuration port.
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam logic REG_ITEM_COUNT = 1'b0;
   localparam logic REG_DEFAULT    = 1'b1;

   // Commands carried in req_tuser.
   localparam logic [CMD_W-1:0] CMD_LOAD_ROW   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_ENTRY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY      = 2'd2;

   // Clamp value for row bounds.
   localparam logic [POS_W-1:0] ENTRY_LIMIT = POS_W'(MAX_ENTRIES);

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_HIT  = 2'd0,
      STATUS_SELF = 2'd1,
      STATUS_MISS = 2'd2
   } status_type;

   // Search sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW_LO,
      ST_ROW_HI,
      ST_BOUNDS,
      ST_PROBE,
      ST_COMPARE,
      ST_CHECK,
      ST_DONE
   } state_type;

   // One stored entry of a row.
   typedef struct packed {
      logic [SECOND_W-1:0] column;
      logic [DIST_W-1:0]   distance;
   } entry_type;

   // Finished query as handed from the sequencer to the output stage.
   typedef struct packed {
      logic               valid;
      status_type         status;
      logic [DIST_W-1:0]  distance;
   } search_result_type;

endpackage

// ===== rtl/ssdl_row_mem.sv =====
// ----------------------------------------------------------------------------
// Row start table
// One write port for row start loads and one read port with registered
// read data for the search sequencer.
// ----------------------------------------------------------------------------
module ssdl_row_mem
   import ssdl_pkg::*;
(
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ROW_ADDR_W-1:0] wr_addr,
   input  logic [POS_W-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ROW_ADDR_W-1:0] rd_addr,
   output logic [POS_W-1:0]      rd_data
);

   logic [POS_W-1:0] mem [MAX_ITEMS+1];
   logic [POS_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ssdl_entry_mem.sv =====
// ----------------------------------------------------------------------------
// Entry table
// Holds the column and the byte distance of every stored entry. One write
// port for entry loads and one registered read port for the search.
// ----------------------------------------------------------------------------
module ssdl_entry_mem
   import ssdl_pkg::*;
(
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [ENTRY_ADDR_W-1:0] wr_addr,
   input  entry_type               wr_data,
   input  logic                    rd_en,
   input  logic [ENTRY_ADDR_W-1:0] rd_addr,
   output entry_type               rd_data
);

   entry_type mem [MAX_ENTRIES];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ssdl_search.sv =====
// ----------------------------------------------------------------------------
// Query sequencer
// Checks the range and the self pair, reads the row bounds and runs a
// lower-bound binary search over the row with one shared midpoint adder
// and one column comparator, one table read per step.
// ----------------------------------------------------------------------------
module ssdl_search
   import ssdl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [FIRST_W-1:0]      first_index,
   input  logic [SECOND_W-1:0]     second_index,
   input  logic [FIRST_W-1:0]      item_count,
   input  logic                    res_take,
   output logic                    idle,
   output search_result_type       result,
   output logic                    row_rd_en,
   output logic [ROW_ADDR_W-1:0]   row_rd_addr,
   input  logic [POS_W-1:0]        row_rd_data,
   output logic                    ent_rd_en,
   output logic [ENTRY_ADDR_W-1:0] ent_rd_addr,
   input  entry_type               ent_rd_data
);

   state_type state_ff, state_in;

   logic [ROW_ADDR_W-1:0] row_ff, row_in;
   logic [SECOND_W-1:0]   col_ff, col_in;
   logic [POS_W-1:0]      lo_ff, lo_in;
   logic [POS_W-1:0]      hi_ff, hi_in;
   logic [POS_W-1:0]      end_ff, end_in;
   logic [POS_W-1:0]      mid_ff, mid_in;
   status_type            status_ff, status_in;
   logic [DIST_W-1:0]     dist_ff, dist_in;

   logic [FIRST_W-1:0]    limit;
   logic [FIRST_W-1:0]    second_ext;
   logic                  out_of_range;
   logic                  self_pair;
   logic                  a_lower;
   logic                  range_open;
   logic [POS_W-1:0]      mid;
   logic [POS_W-1:0]      bound_clamped;

   // Range and self checks on the incoming pair.
   assign second_ext   = FIRST_W'(second_index);
   assign limit        = (item_count > FIRST_W'(MAX_ITEMS)) ? FIRST_W'(MAX_ITEMS)
                                                             : item_count;
   assign out_of_range = (first_index >= limit) || (second_ext >= limit);
   assign self_pair    = (first_index == second_ext);
   assign a_lower      = (first_index < second_ext);

   // Shared search unit: midpoint of the open range and its test.
   assign range_open    = (lo_ff < hi_ff);
   assign mid           = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign bound_clamped = (row_rd_data > ENTRY_LIMIT) ? ENTRY_LIMIT : row_rd_data;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (out_of_range || self_pair) ? ST_DONE : ST_ROW_LO;
            end
         end
         ST_ROW_LO:  state_in = ST_ROW_HI;
         ST_ROW_HI:  state_in = ST_BOUNDS;
         ST_BOUNDS:  state_in = ST_PROBE;
         ST_PROBE:   state_in = range_open ? ST_COMPARE : ST_CHECK;
         ST_COMPARE: state_in = ST_PROBE;
         ST_CHECK:   state_in = ST_DONE;
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // Outputs: table reads and handshake toward the output stage.
   always_comb begin
      idle        = 1'b0;
      row_rd_en   = 1'b0;
      row_rd_addr = row_ff;
      ent_rd_en   = 1'b0;
      ent_rd_addr = lo_ff[ENTRY_ADDR_W-1:0];
      result      = '{valid: 1'b0, status: status_ff, distance: dist_ff};
      case (state_ff)
         ST_IDLE:   idle = 1'b1;
         ST_ROW_LO: row_rd_en = 1'b1;
         ST_ROW_HI: begin
            row_rd_en   = 1'b1;
            row_rd_addr = row_ff + ROW_ADDR_W'(1);
         end
         ST_PROBE: begin
            // Probe the midpoint while the range is open, else the final slot.
            ent_rd_en   = 1'b1;
            ent_rd_addr = range_open ? mid[ENTRY_ADDR_W-1:0] : lo_ff[ENTRY_ADDR_W-1:0];
         end
         ST_DONE:   result.valid = 1'b1;
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      end_in    = end_ff;
      mid_in    = mid_ff;
      status_in = status_ff;
      dist_in   = dist_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // The lower index picks the row, the higher one is searched.
               row_in    = a_lower ? first_index : second_ext;
               col_in    = a_lower ? second_index : first_index[SECOND_W-1:0];
               status_in = out_of_range ? STATUS_MISS : STATUS_SELF;
               dist_in   = '0;
            end
         end
         ST_ROW_HI: lo_in = bound_clamped;
         ST_BOUNDS: begin
            // An end below the start leaves an empty row.
            hi_in  = (bound_clamped < lo_ff) ? lo_ff : bound_clamped;
            end_in = (bound_clamped < lo_ff) ? lo_ff : bound_clamped;
         end
         ST_PROBE: mid_in = mid;
         ST_COMPARE: begin
            if (ent_rd_data.column < col_ff) begin
               lo_in = mid_ff + POS_W'(1);
            end else begin
               hi_in = mid_ff;
            end
         end
         ST_CHECK: begin
            if ((lo_ff < end_ff) && (ent_rd_data.column == col_ff)) begin
               status_in = STATUS_HIT;
               dist_in   = ent_rd_data.distance;
            end else begin
               status_in = STATUS_MISS;
            end
         end
         default: begin
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Search registers.
   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      col_ff    <= col_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      end_ff    <= end_in;
      mid_ff    <= mid_in;
      status_ff <= status_in;
      dist_ff   <= dist_in;
   end

endmodule

// ===== rtl/sparse_symmetric_distance_lookup.sv =====
// ----------------------------------------------------------------------------
// Sparse symmetric distance lookup
// Compressed-row store of a symmetric byte distance matrix with a
// binary-search lookup of index pairs.
// ----------------------------------------------------------------------------
// Usage:
// Words enter on the req_ channel; req_tuser carries the command (load row
// start, load entry, query pair). Loads write the tables when taken and give no
// result. A query gives one result word on the rsp_ channel: rsp_tuser holds
// the status (hit, self pair, miss) and rsp_tdata the byte distance.
// The csr_ port holds item_count (address 0) and default_distance (address 4).
// An out-of-range or self pair goes to the result without a table read; a
// search reads both row bounds, then runs halving steps over the row (at
// most 17), each costing one entry table read and one compare, and ends
// with a check of the final slot. No request is taken while a query
// occupies the block.
// The result sits in an output register: a stalled receiver holds it there,
// loads are still taken, and a further query waits at its end for the
// register to free. Reset empties the pipeline and clears the configuration
// registers, the valid flag and the stored maximum; tables are left as they were.
// ----------------------------------------------------------------------------
module sparse_symmetric_distance_lookup
   import ssdl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request words.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // first_index [12:0], second_index [24:13], position [41:25],
   // entry_distance [49:42], zero fill [55:50]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command [1:0]
   input  logic [CMD_W-1:0]      req_tuser,
   // Result words.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // distance [7:0]
   output logic [DIST_W-1:0]     rsp_tdata,
   // status [1:0]
   output logic [STATUS_W-1:0]   rsp_tuser,
   // Configuration port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [FIRST_W-1:0]   item_count_ff, item_count_in;
   logic [DIST_W-1:0]    default_ff, default_in;
   logic [DIST_W-1:0]    max_stored_ff, max_stored_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [DIST_W-1:0]    rsp_dist_ff, rsp_dist_in;

   logic                 csr_write;
   logic                 req_accept;
   logic [FIRST_W-1:0]   req_first;
   logic [SECOND_W-1:0]  req_second;
   logic [POS_W-1:0]     req_pos;
   logic [DIST_W-1:0]    req_dist;
   logic                 row_wr_en;
   logic                 ent_wr_en;
   entry_type            ent_wr_data;
   logic                 query_start;
   logic                 search_idle;
   logic                 res_take;
   logic [DIST_W-1:0]    eff_default;
   search_result_type    result;

   logic                    row_rd_en;
   logic [ROW_ADDR_W-1:0]   row_rd_addr;
   logic [POS_W-1:0]        row_rd_data;
   logic                    ent_rd_en;
   logic [ENTRY_ADDR_W-1:0] ent_rd_addr;
   entry_type               ent_rd_data;

   // Request word fields.
   assign req_first  = req_tdata[FIRST_LSB  +: FIRST_W];
   assign req_second = req_tdata[SECOND_LSB +: SECOND_W];
   assign req_pos    = req_tdata[POS_LSB    +: POS_W];
   assign req_dist   = req_tdata[DIST_LSB   +: DIST_W];

   // Request decode: loads write the tables at once, queries start a search.
   assign req_tready  = search_idle;
   assign req_accept  = req_tvalid && req_tready;
   assign row_wr_en   = req_accept && (req_tuser == CMD_LOAD_ROW)
                        && (req_first <= FIRST_W'(MAX_ITEMS));
   assign ent_wr_en   = req_accept && (req_tuser == CMD_LOAD_ENTRY)
                        && (req_pos < POS_W'(MAX_ENTRIES));
   assign query_start = req_accept && (req_tuser == CMD_QUERY);
   assign ent_wr_data = '{column: req_second, distance: req_dist};

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      item_count_in = item_count_ff;
      default_in    = default_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_ITEM_COUNT: item_count_in = csr_pwdata[FIRST_W-1:0];
            REG_DEFAULT:    default_in    = csr_pwdata[DIST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_ITEM_COUNT: csr_prdata = CSR_DATA_W'(item_count_ff);
         REG_DEFAULT:    csr_prdata = CSR_DATA_W'(default_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Largest distance stored so far.
   assign max_stored_in = (ent_wr_en && (req_dist > max_stored_ff)) ? req_dist
                                                                    : max_stored_ff;
   assign eff_default   = (default_ff > max_stored_ff) ? default_ff : max_stored_ff;

   // Output register: takes a finished query when it is empty or draining.
   assign res_take = result.valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_dist_in   = rsp_dist_ff;
      if (res_take) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = result.status;
         rsp_dist_in   = (result.status == STATUS_MISS) ? eff_default : result.distance;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_dist_ff;
   assign rsp_tuser  = rsp_status_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= '0;
         default_ff    <= '0;
         max_stored_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_count_ff <= item_count_in;
         default_ff    <= default_in;
         max_stored_ff <= max_stored_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_dist_ff   <= rsp_dist_in;
   end

   ssdl_row_mem u_row_mem (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (req_first[ROW_ADDR_W-1:0]),
      .wr_data (req_pos),
      .rd_en   (row_rd_en),
      .rd_addr (row_rd_addr),
      .rd_data (row_rd_data)
   );

   ssdl_entry_mem u_entry_mem (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (req_pos[ENTRY_ADDR_W-1:0]),
      .wr_data (ent_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   ssdl_search u_search (
      .clock        (clock),
      .reset        (reset),
      .start        (query_start),
      .first_index  (req_first),
      .second_index (req_second),
      .item_count   (item_count_ff),
      .res_take     (res_take),
      .idle         (search_idle),
      .result       (result),
      .row_rd_en    (row_rd_en),
      .row_rd_addr  (row_rd_addr),
      .row_rd_data  (row_rd_data),
      .ent_rd_en    (ent_rd_en),
      .ent_rd_addr  (ent_rd_addr),
      .ent_rd_data  (ent_rd_data)
   );

endmodule

// ===== rtl/ssdl_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker for the sparse symmetric distance lookup
// Watches the top level's ports and flags result words or request timing
// that the block must never show.
// ----------------------------------------------------------------------------
module ssdl_checker
   import ssdl_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [CMD_W-1:0]      req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [DIST_W-1:0]     rsp_tdata,
   input logic [STATUS_W-1:0]   rsp_tuser
);

   // A stalled result word holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // The status code is always one of the three defined ones.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STATUS_HIT) || (rsp_tuser == STATUS_SELF)
                     || (rsp_tuser == STATUS_MISS))
      else $error("result word carries an undefined status");

   // A self pair always reports distance zero.
   a_self_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_SELF) |-> (rsp_tdata == '0))
      else $error("self pair reported a nonzero distance");

   // A query keeps the block busy for at least the cycle after it is taken.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == CMD_QUERY) |=> !req_tready)
      else $error("request taken right after a query");

   // Reset leaves no result word pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word pending after reset");

endmodule

bind sparse_symmetric_distance_lookup ssdl_checker u_ssdl_checker (.*);
